@@ design/srq_pkg.sv @@
// Shared types and codes for the slot ring queue.
`timescale 1ns / 1ps

package srq_pkg;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PULL = 2'd2,
      OP_GET  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_STAGED = 3'd0,
      ST_COMMIT = 3'd1,
      ST_REJECT = 3'd2,
      ST_ITEM   = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_COPY,
      S_LEN,
      S_EMIT
   } state_type;

   localparam logic [6:0] SLOTS_IN_USE_RESET = 7'd64;

endpackage

@@ design/slot_ring_queue_with_stack_pop.sv @@
// Slot ring queue: message slots in a ring, push by word runs, pop/pull/get reads.
`timescale 1ns / 1ps

// Usage notes
// - Request channel: drive start with req_* for one cycle; the word is taken on a
//   rising edge with start high and busy low. Push words arrive one per request;
//   the last one (req_last_word) carries the byte length.
// - Response channel: every word on rsp_* is shown for exactly one cycle with
//   rsp_valid high; rsp_last_result marks the final word for a request. The
//   receiver cannot stall, so there is no back-pressure path.
// - Config: csr_write_enable/csr_write_data write slots_in_use; write only when idle.
// - Timing: each response word shows in the cycle after the edge that set it up.
//   A push word that only stages, or is rejected, answers in the next cycle and
//   leaves busy low. A committing push copies its staged words through the slot
//   store, one per cycle, with busy high; the commit word shows in the cycle
//   after the last of them.
//   Pop/pull/get pass through a length-read state, which also fetches the first
//   payload word; words then stream one per cycle with busy high. An empty slot
//   answers from the length-read state; a get miss answers straight from idle.
// - Rate is set by the slot word store: one word moved per cycle.
// - Reset: after reset the length store is swept to empty, one slot per cycle,
//   with busy high until every slot is cleared; config writes are taken meanwhile.
module slot_ring_queue_with_stack_pop #(
   parameter int QUEUE_SLOTS = 64,
   parameter int SLOT_WORDS  = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_opcode,
   input  logic [15:0]                             req_slot_index,
   input  logic [63:0]                             req_payload_word,
   input  logic [15:0]                             req_payload_bytes,
   input  logic                                    req_last_word,
   output logic                                    rsp_valid,
   output logic [2:0]                              rsp_status,
   output logic [$clog2(SLOT_WORDS * 8 + 1) - 1:0] rsp_size_bytes,
   output logic [63:0]                             rsp_data_word,
   output logic                                    rsp_last_result,
   input  logic                                    csr_write_enable,
   input  logic [6:0]                              csr_write_data
);

   localparam int SLOT_IDX_W = $clog2(QUEUE_SLOTS);
   localparam int WIDX_W     = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
   localparam int WCNT_W     = $clog2(SLOT_WORDS + 1);
   localparam int CAP_BYTES  = SLOT_WORDS * 8;
   localparam int LEN_W      = $clog2(CAP_BYTES + 1);
   localparam int WADDR_W    = $clog2(QUEUE_SLOTS * SLOT_WORDS);
   localparam int QCNT_W     = $clog2(QUEUE_SLOTS + 1);
   localparam int RS_W       = (QCNT_W > 7) ? QCNT_W : 7;
   localparam int WORDS      = QUEUE_SLOTS * SLOT_WORDS;

   // storage
   logic [LEN_W-1:0] len_mem  [QUEUE_SLOTS];
   logic [63:0]      word_mem [WORDS];
   logic [63:0]      stg_mem  [SLOT_WORDS];

   // registers
   srq_pkg::state_type  state_ff, state_in;
   srq_pkg::op_type     op_ff, op_in;
   srq_pkg::status_type status_ff, status_in;
   logic [6:0]            slots_in_use_ff;
   logic [SLOT_IDX_W-1:0] push_ff, push_in;
   logic [SLOT_IDX_W-1:0] pull_ff, pull_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic [SLOT_IDX_W-1:0] clr_ff, clr_in;
   logic [WCNT_W-1:0]     stg_cnt_ff, stg_cnt_in;
   logic [WCNT_W-1:0]     nw_ff, nw_in;
   logic [WCNT_W-1:0]     cnt_ff, cnt_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]      size_ff, size_in;
   logic                  last_ff, last_in;
   logic                  data_sel_ff, data_sel_in;
   logic [LEN_W-1:0]      len_rd_ff;
   logic [63:0]           word_rd_ff;
   logic [63:0]           stg_rd_ff;

   // memory controls
   logic                  len_we, len_re;
   logic [SLOT_IDX_W-1:0] len_waddr, len_raddr;
   logic [LEN_W-1:0]      len_wdata;
   logic                  word_we, word_re;
   logic [WADDR_W-1:0]    word_waddr, word_raddr;
   logic [63:0]           word_wdata;
   logic                  stg_we;
   logic [WIDX_W-1:0]     stg_waddr, stg_raddr;

   // misc
   logic [RS_W-1:0]       ring_n;
   logic [SLOT_IDX_W-1:0] pop_slot;
   logic                  bad_len;
   logic [WCNT_W-1:0]     nw_rd;
   logic [WCNT_W-1:0]     cnt_prev;

   function automatic logic [WADDR_W-1:0] word_addr(input logic [SLOT_IDX_W-1:0] s,
                                                     input logic [WIDX_W-1:0] i);
      return WADDR_W'(s) * WADDR_W'(SLOT_WORDS) + WADDR_W'(i);
   endfunction

   function automatic logic [WCNT_W-1:0] words_of(input logic [LEN_W-1:0] len);
      logic [LEN_W:0] t;
      t = {1'b0, len} + (LEN_W + 1)'(7);
      return WCNT_W'(t >> 3);
   endfunction

   function automatic logic [SLOT_IDX_W-1:0] advance(input logic [SLOT_IDX_W-1:0] p,
                                                     input logic [RS_W-1:0] n);
      logic [RS_W-1:0] t;
      t = RS_W'(p) + RS_W'(1);
      return (t >= n) ? '0 : SLOT_IDX_W'(t);
   endfunction

   // effective ring size: zero acts as one, clipped at the store depth
   always_comb begin
      if (slots_in_use_ff == 7'd0) begin
         ring_n = RS_W'(1);
      end else if (RS_W'(slots_in_use_ff) > RS_W'(QUEUE_SLOTS)) begin
         ring_n = RS_W'(QUEUE_SLOTS);
      end else begin
         ring_n = RS_W'(slots_in_use_ff);
      end
   end

   assign pop_slot = (push_ff != '0) ? push_ff - SLOT_IDX_W'(1) : push_ff;
   assign bad_len  = (req_payload_bytes == 16'd0) || (req_payload_bytes > 16'(CAP_BYTES));
   assign nw_rd    = words_of(len_rd_ff);
   assign cnt_prev = cnt_ff - WCNT_W'(1);

   assign busy            = (state_ff != srq_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_size_bytes  = size_ff;
   assign rsp_last_result = last_ff;
   assign rsp_data_word   = data_sel_ff ? word_rd_ff : 64'd0;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      push_in      = push_ff;
      pull_in      = pull_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      stg_cnt_in   = stg_cnt_ff;
      nw_in        = nw_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      size_in      = '0;
      last_in      = 1'b1;
      data_sel_in  = 1'b0;
      len_we       = 1'b0;
      len_waddr    = slot_ff;
      len_wdata    = '0;
      len_re       = 1'b0;
      len_raddr    = slot_ff;
      word_we      = 1'b0;
      word_waddr   = word_addr(slot_ff, cnt_prev[WIDX_W-1:0]);
      word_wdata   = (cnt_ff <= stg_cnt_ff) ? stg_rd_ff : 64'd0;
      word_re      = 1'b0;
      word_raddr   = '0;
      stg_we       = 1'b0;
      stg_waddr    = stg_cnt_ff[WIDX_W-1:0];
      stg_raddr    = '0;

      case (state_ff)
         srq_pkg::S_CLEAR: begin
            len_we    = 1'b1;
            len_waddr = clr_ff;
            clr_in    = clr_ff + SLOT_IDX_W'(1);
            if (clr_ff == SLOT_IDX_W'(QUEUE_SLOTS - 1)) begin
               state_in = srq_pkg::S_IDLE;
            end
         end

         srq_pkg::S_IDLE: begin
            if (start) begin
               op_in = srq_pkg::op_type'(req_opcode);
               case (req_opcode)
                  srq_pkg::OP_PUSH: begin
                     if (stg_cnt_ff < WCNT_W'(SLOT_WORDS)) begin
                        stg_we     = 1'b1;
                        stg_cnt_in = stg_cnt_ff + WCNT_W'(1);
                     end
                     if (!req_last_word) begin
                        rsp_valid_in = 1'b1;
                        status_in    = srq_pkg::ST_STAGED;
                     end else if (bad_len) begin
                        stg_cnt_in   = '0;
                        rsp_valid_in = 1'b1;
                        status_in    = srq_pkg::ST_REJECT;
                     end else begin
                        slot_in  = push_ff;
                        len_in   = req_payload_bytes[LEN_W-1:0];
                        nw_in    = words_of(req_payload_bytes[LEN_W-1:0]);
                        cnt_in   = '0;
                        state_in = srq_pkg::S_COPY;
                     end
                  end
                  srq_pkg::OP_POP: begin
                     push_in   = pop_slot;
                     slot_in   = pop_slot;
                     len_re    = 1'b1;
                     len_raddr = pop_slot;
                     state_in  = srq_pkg::S_LEN;
                  end
                  srq_pkg::OP_PULL: begin
                     slot_in   = pull_ff;
                     len_re    = 1'b1;
                     len_raddr = pull_ff;
                     state_in  = srq_pkg::S_LEN;
                  end
                  default: begin
                     if (req_slot_index >= 16'(ring_n)) begin
                        rsp_valid_in = 1'b1;
                        status_in    = srq_pkg::ST_EMPTY;
                     end else begin
                        slot_in   = req_slot_index[SLOT_IDX_W-1:0];
                        len_re    = 1'b1;
                        len_raddr = req_slot_index[SLOT_IDX_W-1:0];
                        state_in  = srq_pkg::S_LEN;
                     end
                  end
               endcase
            end
         end

         // staging read runs one word ahead of the slot write
         srq_pkg::S_COPY: begin
            if (cnt_ff < nw_ff) begin
               stg_raddr = cnt_ff[WIDX_W-1:0];
            end
            if (cnt_ff != '0) begin
               word_we = 1'b1;
            end
            if (cnt_ff == nw_ff) begin
               len_we       = 1'b1;
               len_wdata    = len_ff;
               push_in      = advance(push_ff, ring_n);
               stg_cnt_in   = '0;
               rsp_valid_in = 1'b1;
               status_in    = srq_pkg::ST_COMMIT;
               size_in      = len_ff;
               state_in     = srq_pkg::S_IDLE;
            end else begin
               cnt_in = cnt_ff + WCNT_W'(1);
            end
         end

         srq_pkg::S_LEN: begin
            if (len_rd_ff == '0) begin
               rsp_valid_in = 1'b1;
               status_in    = srq_pkg::ST_EMPTY;
               state_in     = srq_pkg::S_IDLE;
            end else begin
               if (op_ff == srq_pkg::OP_PULL) begin
                  pull_in = advance(pull_ff, ring_n);
               end
               word_re      = 1'b1;
               word_raddr   = word_addr(slot_ff, '0);
               rsp_valid_in = 1'b1;
               status_in    = srq_pkg::ST_ITEM;
               size_in      = len_rd_ff;
               data_sel_in  = 1'b1;
               last_in      = (nw_rd == WCNT_W'(1));
               len_in       = len_rd_ff;
               nw_in        = nw_rd;
               if (nw_rd == WCNT_W'(1)) begin
                  len_we   = (op_ff != srq_pkg::OP_GET);
                  state_in = srq_pkg::S_IDLE;
               end else begin
                  cnt_in   = WCNT_W'(1);
                  state_in = srq_pkg::S_EMIT;
               end
            end
         end

         srq_pkg::S_EMIT: begin
            word_re      = 1'b1;
            word_raddr   = word_addr(slot_ff, cnt_ff[WIDX_W-1:0]);
            rsp_valid_in = 1'b1;
            status_in    = srq_pkg::ST_ITEM;
            size_in      = len_ff;
            data_sel_in  = 1'b1;
            last_in      = (cnt_ff == nw_ff - WCNT_W'(1));
            if (cnt_ff == nw_ff - WCNT_W'(1)) begin
               len_we   = (op_ff != srq_pkg::OP_GET);
               state_in = srq_pkg::S_IDLE;
            end else begin
               cnt_in = cnt_ff + WCNT_W'(1);
            end
         end

         default: begin
            state_in = srq_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= srq_pkg::S_CLEAR;
         clr_ff          <= '0;
         push_ff         <= '0;
         pull_ff         <= '0;
         stg_cnt_ff      <= '0;
         slots_in_use_ff <= srq_pkg::SLOTS_IN_USE_RESET;
         rsp_valid_ff    <= 1'b0;
         data_sel_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         push_ff      <= push_in;
         pull_ff      <= pull_in;
         stg_cnt_ff   <= stg_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         data_sel_ff  <= data_sel_in;
         if (csr_write_enable) begin
            slots_in_use_ff <= csr_write_data;
         end
      end
   end

   // working and response payload
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      slot_ff   <= slot_in;
      nw_ff     <= nw_in;
      cnt_ff    <= cnt_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      size_ff   <= size_in;
      last_ff   <= last_in;
   end

   // length store
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      if (len_re) begin
         len_rd_ff <= len_mem[len_raddr];
      end
   end

   // slot word store
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_waddr] <= word_wdata;
      end
      if (word_re) begin
         word_rd_ff <= word_mem[word_raddr];
      end
   end

   // staging store
   always_ff @(posedge clock) begin
      if (stg_we) begin
         stg_mem[stg_waddr] <= req_payload_word;
      end
      stg_rd_ff <= stg_mem[stg_raddr];
   end

endmodule
